[rtl/hvn_pkg.sv]
package hvn_pkg;

  localparam int MaxSide  = 256;
  localparam int AddrW    = $clog2(MaxSide) * 2;
  localparam int FracBits = 14;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;

  localparam logic [CfgIdxW-1:0] REG_GRID_WIDTH     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GRID_HEIGHT    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT_DIVISOR = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] J_BASE   = 2'd0;
  localparam logic [1:0] J_RIGHT  = 2'd1;
  localparam logic [1:0] J_BELOW  = 2'd2;
  localparam logic [1:0] J_UNUSED = 2'd3;

  localparam logic [3:0] TopBit    = 4'(FracBits);
  localparam logic [3:0] ReadLast  = 4'd15;
  localparam logic [1:0] CompLast  = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] height;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               status;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_LEN, ST_CINIT, ST_CT1, ST_CT2, ST_FIN
  } state_t;

  typedef struct packed {
    logic       wr_en;
    logic       start;
    logic       rd_en;
    logic [3:0] rd_idx;
    logic       len_en;
    logic [1:0] sel;
    logic       comp_init;
    logic       trial_sq;
    logic       trial_cmp;
    logic [3:0] bit_idx;
    logic       comp_done;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic oob;
    logic len_zero;
    logic out_busy;
  } status_t;

endpackage

[rtl/hvn_ctrl.sv]
module hvn_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_cmd,
  output logic           in_ready,
  input  hvn_pkg::status_t st,
  output hvn_pkg::cmd_t    cmd
);
  import hvn_pkg::*;

  state_t     state, state_next;
  logic [3:0] cnt, cnt_next;
  logic [1:0] comp, comp_next;
  logic [3:0] bitc, bitc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      comp  <= '0;
      bitc  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      comp  <= comp_next;
      bitc  <= bitc_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    comp_next  = comp;
    bitc_next  = bitc;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            cnt_next   = '0;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (st.oob) begin
          state_next = ST_FIN;
        end else begin
          cmd.rd_en  = (cnt[1:0] != J_UNUSED);
          cmd.rd_idx = cnt;
          if (cnt == ReadLast) begin
            cnt_next   = '0;
            state_next = ST_LEN;
          end else begin
            cnt_next = cnt + 4'd1;
          end
        end
      end
      ST_LEN: begin
        cmd.len_en = 1'b1;
        cmd.sel    = cnt[1:0];
        if (cnt[1:0] == CompLast) begin
          comp_next  = '0;
          state_next = ST_CINIT;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_CINIT: begin
        if (st.len_zero) begin
          state_next = ST_FIN;
        end else begin
          cmd.comp_init = 1'b1;
          cmd.sel       = comp;
          bitc_next     = TopBit;
          state_next    = ST_CT1;
        end
      end
      ST_CT1: begin
        cmd.trial_sq = 1'b1;
        cmd.bit_idx  = bitc;
        state_next   = ST_CT2;
      end
      ST_CT2: begin
        cmd.trial_cmp = 1'b1;
        cmd.bit_idx   = bitc;
        cmd.sel       = comp;
        if (bitc == 4'd0) begin
          cmd.comp_done = 1'b1;
          if (comp == CompLast) begin
            state_next = ST_FIN;
          end else begin
            comp_next  = comp + 2'd1;
            state_next = ST_CINIT;
          end
        end else begin
          bitc_next  = bitc - 4'd1;
          state_next = ST_CT1;
        end
      end
      ST_FIN: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/hvn_datapath.sv]
module hvn_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  hvn_pkg::in_beat_t             in_data,
  input  logic                          cfg_we,
  input  logic [hvn_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hvn_pkg::CfgDataW-1:0]  cfg_data,
  input  hvn_pkg::cmd_t                 cmd,
  output hvn_pkg::status_t              st,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hvn_pkg::out_beat_t            out_data
);
  import hvn_pkg::*;

  logic [8:0] grid_width, grid_height;
  logic [7:0] height_divisor;
  logic [8:0] w, h;

  logic [7:0] mem [2**AddrW];
  logic [7:0] rd_data;
  logic [7:0] row, col;

  logic               rd_ok_d;
  logic [1:0]         j_d;
  logic [7:0]         a;
  logic signed [10:0] sx, sy, sz;
  logic [21:0]        len2;

  logic               row_up, col_left, face_ok;
  logic [7:0]         fr, fc;
  logic [AddrW-1:0]   rd_addr;

  logic signed [10:0] sel_s;
  logic [9:0]         sel_mag;
  logic [19:0]        sq;
  logic [19:0]        rhs;
  logic               neg_c;
  logic [14:0]        q, t, q_new;
  logic [15:0]        odd;
  logic [31:0]        odd_sq;
  logic [31:0]        u;
  logic [53:0]        p;
  logic [15:0]        qs;
  logic signed [15:0] nx, ny, nz;
  logic signed [8:0]  diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= 9'd100;
      grid_height    <= 9'd100;
      height_divisor <= 8'd12;
    end else if (cfg_we) begin
      if (cfg_index == REG_GRID_WIDTH)     grid_width     <= cfg_data;
      if (cfg_index == REG_GRID_HEIGHT)    grid_height    <= cfg_data;
      if (cfg_index == REG_HEIGHT_DIVISOR) height_divisor <= cfg_data[7:0];
    end
  end

  assign w = (grid_width  > 9'(MaxSide)) ? 9'(MaxSide) : grid_width;
  assign h = (grid_height > 9'(MaxSide)) ? 9'(MaxSide) : grid_height;

  assign row_up   = ~cmd.rd_idx[3];
  assign col_left = ~cmd.rd_idx[2];
  assign fr       = row - {7'd0, row_up};
  assign fc       = col - {7'd0, col_left};
  assign face_ok  = !(row_up && row == 8'd0) && !(col_left && col == 8'd0)
                  && ({1'b0, fr} + 9'd1 < h) && ({1'b0, fc} + 9'd1 < w);

  always_comb begin
    case (cmd.rd_idx[1:0])
      J_RIGHT: rd_addr = {fr, fc + 8'd1};
      J_BELOW: rd_addr = {fr + 8'd1, fc};
      default: rd_addr = {fr, fc};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[{in_data.row, in_data.col}] <= in_data.height;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_ok_d <= 1'b0;
    else     rd_ok_d <= cmd.rd_en && face_ok;
  end

  assign diff = $signed({1'b0, a}) - $signed({1'b0, rd_data});

  always_comb begin
    case (cmd.sel)
      2'd1:    sel_s = sy;
      2'd2:    sel_s = sz;
      default: sel_s = sx;
    endcase
  end
  assign sel_mag = sel_s[10] ? 10'(-sel_s) : sel_s[9:0];
  assign sq      = sel_mag * sel_mag;

  assign t      = q | (15'd1 << cmd.bit_idx);
  assign odd    = {t, 1'b0} - 16'd1;
  assign odd_sq = odd * odd;
  assign p      = u * len2;
  assign q_new  = (p <= {4'b0000, rhs, 30'd0}) ? t : q;
  assign qs     = neg_c ? -{1'b0, q_new} : {1'b0, q_new};

  always_ff @(posedge clk) begin
    j_d <= cmd.rd_idx[1:0];
    if (cmd.start) begin
      row  <= in_data.row;
      col  <= in_data.col;
      sx   <= '0;
      sy   <= '0;
      sz   <= '0;
      len2 <= '0;
      nx   <= '0;
      ny   <= '0;
      nz   <= '0;
    end
    if (rd_ok_d) begin
      unique case (j_d)
        J_BASE:  a <= rd_data;
        J_RIGHT: sx <= sx + 11'(diff);
        J_BELOW: begin
          sz <= sz + 11'(diff);
          sy <= sy + $signed({3'd0, height_divisor});
        end
        default: ;
      endcase
    end
    if (cmd.len_en) len2 <= len2 + 22'(sq);
    if (cmd.comp_init) begin
      rhs   <= sq;
      neg_c <= sel_s[10];
      q     <= '0;
    end
    if (cmd.trial_sq)  u <= odd_sq;
    if (cmd.trial_cmp) q <= q_new;
    if (cmd.comp_done) begin
      case (cmd.sel)
        2'd1:    ny <= $signed(qs);
        2'd2:    nz <= $signed(qs);
        default: nx <= $signed(qs);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.status   <= st.oob;
      out_data.normal_x <= st.oob ? '0 : nx;
      out_data.normal_y <= st.oob ? '0 : ny;
      out_data.normal_z <= st.oob ? '0 : nz;
    end
  end

  assign st.oob      = ({1'b0, row} >= h) || ({1'b0, col} >= w);
  assign st.len_zero = (len2 == 22'd0);
  assign st.out_busy = out_valid && !out_ready;

endmodule

[rtl/heightmap_vertex_normals_core.sv]
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_data (cmd, row, col, height)
// out     | output    | out_valid / out_ready | out_data (normal_x/y/z, status)
// cfg     | input     | cfg_we                | cfg_index, cfg_data
// A write beat is written to the store as it is accepted. A query first reads heights
// from the single-port store, then sums the squared length, then per component runs a
// setup state and a square state and a compare state per result bit over 15 bits, then loads.
// An out-of-grid query goes straight from the reads to the load. Reset clears control and config;
// the height store is not cleared. A query result waits in the output
// register; a finished query stalls only while that register is still full.
module heightmap_vertex_normals_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hvn_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hvn_pkg::out_beat_t            out_data,
  input  logic                          cfg_we,
  input  logic [hvn_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hvn_pkg::CfgDataW-1:0]  cfg_data
);
  import hvn_pkg::*;

  cmd_t    cmd;
  status_t st;

  hvn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  hvn_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result beat appeared without a load");

  a_rd_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> cmd.rd_idx[1:0] != J_UNUSED)
    else $error("read issued in unused slot");

  a_done_cmp: assert property (@(posedge clk) disable iff (rst)
    cmd.comp_done |-> cmd.trial_cmp && cmd.bit_idx == 4'd0)
    else $error("component stored before last bit");

  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |->
      out_data.normal_x == 16'sd0 && out_data.normal_y == 16'sd0
      && out_data.normal_z == 16'sd0)
    else $error("error status with nonzero normal");
`endif

endmodule
